FILE: rtl/core/pjb_pkg.sv
// shared types and constants of the playout jitter buffer
package pjb_pkg;

   // request opcodes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_PULL  = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   // register word indexes on the csr port
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_PREFILL = 3'd0;
   localparam logic [2:0] REG_LOW     = 3'd1;
   localparam logic [2:0] REG_HIGH    = 3'd2;
   localparam logic [2:0] REG_LIMIT   = 3'd3;
   localparam logic [2:0] REG_OUTAGE  = 3'd4;

   localparam logic [16:0] PREFILL_RST = 17'd8640;
   localparam logic [16:0] LOW_RST     = 17'd4320;
   localparam logic [16:0] HIGH_RST    = 17'd14400;
   localparam logic [16:0] LIMIT_RST   = 17'd48000;
   localparam logic [15:0] OUTAGE_RST  = 16'd3840;

   // fade quotient width
   localparam int unsigned QUO_W  = 16;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] sample_in;
      logic               block_start;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic [16:0]        fill_level;
      logic [31:0]        dropped_total;
      logic               playing;
      logic               concealing;
   } rsp_type;

   typedef struct packed {
      logic [16:0] prefill_level;
      logic [16:0] low_water;
      logic [16:0] high_water;
      logic [16:0] fifo_limit;
      logic [15:0] outage_limit;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic step;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic fade;
   } status_type;

endpackage

FILE: rtl/core/pjb_ram.sv
// generic single-port-write ram with registered read
module pjb_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/core/pjb_csr.sv
// configuration registers behind the apb-style port
module pjb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pjb_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output pjb_pkg::cfg_type                    cfg
);
   import pjb_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr;
   logic [2:0] idx;

   assign wr  = psel & penable & pwrite;
   assign idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_PREFILL: cfg_in.prefill_level = pwdata[16:0];
            REG_LOW:     cfg_in.low_water     = pwdata[16:0];
            REG_HIGH:    cfg_in.high_water    = pwdata[16:0];
            REG_LIMIT:   cfg_in.fifo_limit    = pwdata[16:0];
            REG_OUTAGE:  cfg_in.outage_limit  = pwdata[15:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prefill_level <= PREFILL_RST;
         cfg_ff.low_water     <= LOW_RST;
         cfg_ff.high_water    <= HIGH_RST;
         cfg_ff.fifo_limit    <= LIMIT_RST;
         cfg_ff.outage_limit  <= OUTAGE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_PREFILL: prdata = 32'(cfg_ff.prefill_level);
         REG_LOW:     prdata = 32'(cfg_ff.low_water);
         REG_HIGH:    prdata = 32'(cfg_ff.high_water);
         REG_LIMIT:   prdata = 32'(cfg_ff.fifo_limit);
         REG_OUTAGE:  prdata = 32'(cfg_ff.outage_limit);
         default:     prdata = 32'd0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;
endmodule

FILE: rtl/core/pjb_ctrl.sv
// sequencer: accept, execute, fade scaling, finish
module pjb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  pjb_pkg::status_type   status,
   output pjb_pkg::cmd_type      cmd,
   output logic                  busy
);
   import pjb_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]        state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.fade) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV:  state_in = ST_FIN;
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.load = (state_ff == ST_IDLE) & start;
   assign cmd.exec = (state_ff == ST_EXEC);
   assign cmd.step = (state_ff == ST_DIV);
   assign cmd.fin  = (state_ff == ST_FIN);
   assign busy     = (state_ff != ST_IDLE);
endmodule

FILE: rtl/core/pjb_dpath.sv
// fifo pointers, playout state, drift correction and fade scaling
module pjb_dpath #(
   parameter int unsigned FIFO_DEPTH     = 65536,
   parameter int unsigned CONCEAL_FRAMES = 576,
   parameter int unsigned DRIFT_PERIOD   = 192
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pjb_pkg::cmd_type      cmd,
   input  pjb_pkg::req_type      req,
   input  pjb_pkg::cfg_type      cfg,
   output pjb_pkg::status_type   status,
   output logic                  rsp_strobe,
   output pjb_pkg::rsp_type      rsp
);
   import pjb_pkg::*;

   localparam int unsigned AW  = $clog2(FIFO_DEPTH);
   localparam int unsigned CW  = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned SW  = CW + 1;
   localparam int unsigned PHW = $clog2(DRIFT_PERIOD);
   localparam int unsigned GW  = $clog2(CONCEAL_FRAMES + 1);
   localparam int unsigned NW  = GW + 17;
   localparam int unsigned DW  = $clog2(2 * CONCEAL_FRAMES);
   localparam int unsigned RK  = NW + DW;

   localparam logic [SW-1:0]  DEPTH_S  = SW'(FIFO_DEPTH);
   localparam logic [16:0]    DEPTH_17 = 17'(FIFO_DEPTH);
   localparam logic [PHW:0]   PERIOD   = (PHW + 1)'(DRIFT_PERIOD);
   localparam logic [15:0]    CF_16    = 16'(CONCEAL_FRAMES);
   localparam logic [GW-1:0]  CF_G     = GW'(CONCEAL_FRAMES);
   localparam logic [NW-1:0]  CF_N     = NW'(CONCEAL_FRAMES);
   // rounded-up reciprocal of 2*CONCEAL_FRAMES, exact for any numerator below 2**NW
   localparam logic [NW:0]    RECIP    = (NW + 1)'(((64'd1 << RK) + 64'(2 * CONCEAL_FRAMES)
                                                    - 64'd1) / 64'(2 * CONCEAL_FRAMES));

   function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [CW-1:0] k);
      logic [SW-1:0] s;
      s = SW'(p) + SW'(k);
      if (s >= DEPTH_S) begin
         s = s - DEPTH_S;
      end
      return s[AW-1:0];
   endfunction

   req_type          req_ff;
   logic [AW-1:0]    rp_ff, rp_in, wp_ff, wp_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [15:0]      held_ff, held_in;
   logic [15:0]      gap_ff, gap_in;
   logic [PHW-1:0]   phase_ff, phase_in;
   logic             playing_ff, playing_in, muted_ff, muted_in;
   logic             low_ff, low_in, high_ff, high_in;
   logic [31:0]      drop_ff, drop_in;
   logic             neg_ff, neg_in;
   logic [NW-1:0]    num_ff, num_in;
   logic [QUO_W-1:0] q_ff, q_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic             ram_we;
   logic [15:0]      ram_rdata;

   // block start resolution
   logic [16:0]      fill_ext;
   logic             play_b, mute_b, low_b, high_b;
   logic [15:0]      gap_b;

   // push overflow
   logic [16:0]      limit, fill_p1, over_diff, drop_17;
   logic [CW-1:0]    drop_amt;

   // drift and pops
   logic [PHW:0]     phase_sum;
   logic [PHW-1:0]   phase_nx;
   logic             at_mark, pop1, pop2;
   logic [CW-1:0]    fill_after1;
   logic [1:0]       pops;

   // fade
   logic [15:0]      gap_inc, mag;
   logic [GW-1:0]    frac;
   logic [QUO_W+GW-1:0] prod;
   logic [NW-1:0]    n_val;
   logic             outage;
   logic             fade;

   // reciprocal scaling
   logic [2*NW:0]    recip_prod;

   pjb_ram #(
      .WIDTH(16),
      .DEPTH(FIFO_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (req_ff.sample_in),
      .re    (cmd.load),
      .raddr (rp_ff),
      .rdata (ram_rdata)
   );

   assign fill_ext = 17'(fill_ff);

   always_comb begin
      play_b = playing_ff;
      mute_b = muted_ff;
      gap_b  = gap_ff;
      low_b  = low_ff;
      high_b = high_ff;
      if (req_ff.block_start) begin
         if (!playing_ff) begin
            if (fill_ext < cfg.prefill_level) begin
               mute_b = 1'b1;
            end else begin
               play_b = 1'b1;
               gap_b  = '0;
               mute_b = 1'b0;
            end
         end else begin
            mute_b = 1'b0;
         end
         if (!mute_b) begin
            low_b  = fill_ext < cfg.low_water;
            high_b = fill_ext > cfg.high_water;
         end
      end
   end

   // overflow drops min(fill+1-limit, fill) oldest samples
   assign limit     = (cfg.fifo_limit < DEPTH_17) ? cfg.fifo_limit : DEPTH_17;
   assign fill_p1   = fill_ext + 17'd1;
   assign over_diff = fill_p1 - limit;
   assign drop_17   = (fill_p1 <= limit) ? 17'd0 :
                      (over_diff > fill_ext) ? fill_ext : over_diff;
   assign drop_amt  = CW'(drop_17);

   assign phase_sum   = (PHW + 1)'(phase_ff) + (PHW + 1)'(1);
   assign phase_nx    = (phase_sum == PERIOD) ? '0 : phase_sum[PHW-1:0];
   assign at_mark     = (phase_nx == '0);
   assign pop1        = !(low_b & at_mark);
   assign fill_after1 = fill_ff - CW'(pop1);
   assign pop2        = high_b & at_mark & (fill_after1 != '0);
   assign pops        = 2'(pop1) + 2'(pop2);

   assign gap_inc = (gap_b == 16'hFFFF) ? gap_b : gap_b + 16'd1;
   assign outage  = gap_inc > cfg.outage_limit;
   assign mag     = held_ff[15] ? (~held_ff + 16'd1) : held_ff;
   assign frac    = (gap_inc > CF_16) ? '0 : CF_G - GW'(gap_inc);
   assign prod    = (QUO_W + GW)'(mag) * (QUO_W + GW)'(frac);
   // rounding half away from zero on the magnitude
   assign n_val   = {prod, 1'b0} + CF_N;

   assign fade        = (req_ff.opcode == OP_PULL) & !mute_b & (fill_ff == '0);
   assign status.fade = fade;

   assign recip_prod = (2 * NW + 1)'(num_ff) * (2 * NW + 1)'(RECIP);

   always_comb begin
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      held_in       = held_ff;
      gap_in        = gap_ff;
      phase_in      = phase_ff;
      playing_in    = playing_ff;
      muted_in      = muted_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      drop_in       = drop_ff;
      neg_in        = neg_ff;
      num_in        = num_ff;
      q_in          = q_ff;
      ram_we        = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (cmd.exec) begin
         case (req_ff.opcode)
            OP_PUSH: begin
               rp_in   = adv(rp_ff, drop_amt);
               fill_in = fill_ff - drop_amt + CW'(1);
               drop_in = drop_ff + 32'(drop_amt);
               ram_we  = 1'b1;
               wp_in   = adv(wp_ff, CW'(1));
            end
            OP_FLUSH: begin
               rp_in      = '0;
               wp_in      = '0;
               fill_in    = '0;
               held_in    = '0;
               gap_in     = '0;
               phase_in   = '0;
               playing_in = 1'b0;
               muted_in   = 1'b1;
               low_in     = 1'b0;
               high_in    = 1'b0;
            end
            OP_PULL: begin
               playing_in = play_b;
               muted_in   = mute_b;
               gap_in     = gap_b;
               low_in     = low_b;
               high_in    = high_b;
               rsp_in.sample_out = '0;
               rsp_in.concealing = 1'b0;
               if (!mute_b) begin
                  if (fill_ff != '0) begin
                     phase_in = phase_nx;
                     held_in  = ram_rdata;
                     rp_in    = adv(rp_ff, CW'(pops));
                     fill_in  = fill_ff - CW'(pops);
                     gap_in   = '0;
                     rsp_in.sample_out = ram_rdata;
                  end else begin
                     gap_in = gap_inc;
                     neg_in = held_ff[15];
                     num_in = n_val;
                     if (outage) begin
                        playing_in = 1'b0;
                        held_in    = '0;
                     end
                  end
               end
               rsp_strobe_in        = !fade;
               rsp_in.fill_level    = 17'(fill_in);
               rsp_in.dropped_total = drop_ff;
               rsp_in.playing       = playing_in;
            end
            default: ;
         endcase
      end

      if (cmd.step) begin
         q_in = recip_prod[RK +: QUO_W];
      end

      if (cmd.fin) begin
         rsp_strobe_in        = 1'b1;
         rsp_in.sample_out    = neg_ff ? (~q_ff + 16'd1) : q_ff;
         rsp_in.fill_level    = 17'(fill_ff);
         rsp_in.dropped_total = drop_ff;
         rsp_in.playing       = playing_ff;
         rsp_in.concealing    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff         <= '0;
         wp_ff         <= '0;
         fill_ff       <= '0;
         held_ff       <= '0;
         gap_ff        <= '0;
         phase_ff      <= '0;
         playing_ff    <= 1'b0;
         muted_ff      <= 1'b1;
         low_ff        <= 1'b0;
         high_ff       <= 1'b0;
         drop_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
         held_ff       <= held_in;
         gap_ff        <= gap_in;
         phase_ff      <= phase_in;
         playing_ff    <= playing_in;
         muted_ff      <= muted_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         drop_ff       <= drop_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
      neg_ff <= neg_in;
      num_ff <= num_in;
      q_ff   <= q_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;
endmodule

FILE: rtl/core/playout_jitter_buffer_top.sv
// push, pull and flush: the accept cycle reads the sample memory and loads the request, the execute
// state then updates the fifo state; a pull's result strobes in the cycle after it, when the next item can go
// a pull from an empty fifo while playing also passes through the divide and finish states, which scale the
// fade by a reciprocal multiply and sign it; one item is in flight at a time and busy is high while it runs
// synchronous reset clears pointers, counters and flags and loads the register defaults;
// the sample memory is not cleared and needs no clearing pass
module playout_jitter_buffer_top #(
   parameter int unsigned FIFO_DEPTH     = 65536,
   parameter int unsigned CONCEAL_FRAMES = 576,
   parameter int unsigned DRIFT_PERIOD   = 192
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  pjb_pkg::req_type               req_data,
   output logic                           rsp_strobe,
   output pjb_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pjb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import pjb_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   pjb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pjb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   pjb_dpath #(
      .FIFO_DEPTH     (FIFO_DEPTH),
      .CONCEAL_FRAMES (CONCEAL_FRAMES),
      .DRIFT_PERIOD   (DRIFT_PERIOD)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_data),
      .cfg        (cfg),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );
endmodule

FILE: rtl/core/pjb_checker.sv
// port-level checks on the playout jitter buffer, bound to the top level
module pjb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input pjb_pkg::req_type               req_data,
   input logic                           rsp_strobe,
   input pjb_pkg::rsp_type               rsp_data,
   input logic                           psel,
   input logic                           penable,
   input logic                           pwrite,
   input logic [pjb_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [31:0]                    pwdata,
   input logic [31:0]                    prdata,
   input logic                           pready
);
   import pjb_pkg::*;

   // an accepted transfer keeps the block busy for the next cycle
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("accepted transfer did not raise busy");

   // results leave only once the item is finished
   assert property (@(posedge clock) rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // no two results in adjacent cycles
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back results");

   // concealment only ever comes from an empty fifo
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.concealing |-> rsp_data.fill_level == 17'd0)
      else $error("concealed frame with samples held");
endmodule

bind playout_jitter_buffer_top pjb_checker u_checker (.*);
